// ----- sv/ce_pkg.sv -----
// ----------------------------------------------------------------------------
// ce_pkg
// Shared widths for the covariance eccentricity pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package ce_pkg;
   localparam int IN_W   = 24;
   localparam int OUT_W  = 16;
   localparam int D_W    = 50;   // (xx-yy)^2 + 4xy^2 < 2^50
   localparam int S_W    = 25;   // floor(sqrt(D))
   localparam int N_W    = 26;   // xx + yy + S
endpackage
`default_nettype wire

// ----- sv/covariance_eccentricity.sv -----
// ----------------------------------------------------------------------------
// covariance_eccentricity
// Eccentricity of a 2x2 covariance ellipse, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one request per cycle and returns one result per request, in order.
// The pipeline holds, in order, these stages:
// three stages for the magnitudes, the squares and their sum, one bit per
// stage for the discriminant root, one stage for the denominator, one quotient
// bit per stage for the divider, one bit per stage for the final root and the
// output register. The whole pipe advances only while the output register is
// empty or being read, so a stall holds every stage in place.
`default_nettype none
module covariance_eccentricity import ce_pkg::*; #(
   parameter int OUT_FRAC_BITS = 15
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [IN_W-1:0]         req_cov_xx,
   input  wire logic [IN_W-1:0]         req_cov_yy,
   input  wire logic signed [IN_W-1:0]  req_cov_xy,
   input  wire logic                    req_stats_valid,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [OUT_W-1:0]             rsp_eccentricity,
   output logic                         rsp_not_round
);
   localparam int F2  = 2 * OUT_FRAC_BITS;
   localparam int QW  = S_W + 1 + F2 + 1;       // quotient bits, 2S*2^2F < 2^QW
   localparam int QWE = QW + (QW % 2);           // even width for root
   localparam int EW  = QWE / 2;

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // stage 1: magnitudes
   logic            v1_ff, ok1_ff;
   logic [IN_W-1:0] dif1_ff, xym1_ff;
   logic [IN_W:0]   t1_ff;
   logic [IN_W-1:0] xym_in;
   assign xym_in = req_cov_xy[IN_W-1] ? IN_W'(-req_cov_xy) : req_cov_xy;
   // note: -(-2^23) magnitude 2^23 fits unsigned 24 bits

   // stage 2: squares
   logic              v2_ff, ok2_ff;
   logic [2*IN_W-1:0] sq_a_ff, sq_b_ff;
   logic [IN_W:0]     t2_ff;

   // stage 3 (sum) is entry 0 of the discriminant root
   logic [D_W-1:0]  rr_ff [S_W+1];
   logic [S_W-1:0]  rs_ff [S_W+1];
   logic [IN_W:0]   rt_ff [S_W+1];
   logic            rv_ff [S_W+1];
   logic            rok_ff[S_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; rv_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid; v2_ff <= v1_ff; rv_ff[0] <= v2_ff;
      end
      if (adv) begin
         ok1_ff  <= req_stats_valid;
         dif1_ff <= (req_cov_xx >= req_cov_yy) ? req_cov_xx - req_cov_yy
                                               : req_cov_yy - req_cov_xx;
         xym1_ff <= xym_in;
         t1_ff   <= {1'b0, req_cov_xx} + {1'b0, req_cov_yy};
         ok2_ff  <= ok1_ff;
         sq_a_ff <= dif1_ff * dif1_ff;
         sq_b_ff <= xym1_ff * xym1_ff;
         t2_ff   <= t1_ff;
         rok_ff[0] <= ok2_ff;
         rr_ff[0]  <= D_W'(sq_a_ff) + {sq_b_ff, 2'b00};
         rs_ff[0]  <= '0;
         rt_ff[0]  <= t2_ff;
      end
   end

   // discriminant root: one result bit per stage
   for (genvar k = 0; k < S_W; k++) begin : g_sroot
      localparam int B = S_W - 1 - k;
      logic [D_W+1:0] trial;
      assign trial = {2'b00, rr_ff[k]}
                   - (({2'b00, (D_W)'(rs_ff[k])} << (B + 1)) | ((D_W+2)'(1) << (2 * B)));
      always_ff @(posedge clock) begin
         if (reset) rv_ff[k+1] <= 1'b0;
         else if (adv) rv_ff[k+1] <= rv_ff[k];
         if (adv) begin
            rok_ff[k+1] <= rok_ff[k];
            rt_ff[k+1]  <= rt_ff[k];
            if (!trial[D_W+1]) begin
               rr_ff[k+1] <= trial[D_W-1:0];
               rs_ff[k+1] <= rs_ff[k] | (S_W'(1) << B);
            end else begin
               rr_ff[k+1] <= rr_ff[k];
               rs_ff[k+1] <= rs_ff[k];
            end
         end
      end
   end

   // denominator and flag: entry 0 of the divider
   logic [QW-1:0]  qn_ff [QW+1];
   logic [N_W:0]   qr_ff [QW+1];
   logic [N_W-1:0] qd_ff [QW+1];
   logic           qv_ff [QW+1];
   logic           qb_ff [QW+1];
   logic [N_W-1:0] n_in;
   assign n_in = N_W'(rt_ff[S_W]) + N_W'(rs_ff[S_W]);
   always_ff @(posedge clock) begin
      if (reset) qv_ff[0] <= 1'b0;
      else if (adv) qv_ff[0] <= rv_ff[S_W];
      if (adv) begin
         qd_ff[0] <= n_in;
         qb_ff[0] <= !rok_ff[S_W] || (n_in == '0);
         qn_ff[0] <= QW'({rs_ff[S_W], 1'b0}) << F2;
         qr_ff[0] <= '0;
      end
   end

   // restoring divider: one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [N_W+1:0] sh, df;
      assign sh = {qr_ff[k], qn_ff[k][QW-1]};
      assign df = sh - {2'b00, qd_ff[k]};
      always_ff @(posedge clock) begin
         if (reset) qv_ff[k+1] <= 1'b0;
         else if (adv) qv_ff[k+1] <= qv_ff[k];
         if (adv) begin
            qb_ff[k+1] <= qb_ff[k];
            qd_ff[k+1] <= qd_ff[k];
            if (!df[N_W+1]) begin
               qr_ff[k+1] <= df[N_W:0];
               qn_ff[k+1] <= {qn_ff[k][QW-2:0], 1'b1};
            end else begin
               qr_ff[k+1] <= sh[N_W:0];
               qn_ff[k+1] <= {qn_ff[k][QW-2:0], 1'b0};
            end
         end
      end
   end

   // final root: one bit per stage
   logic [QWE-1:0] er_ff [1:EW];
   logic [EW-1:0]  es_ff [1:EW];
   logic           ev_ff [1:EW];
   logic           eb_ff [1:EW];
   for (genvar k = 0; k < EW; k++) begin : g_eroot
      localparam int B = EW - 1 - k;
      logic [QWE-1:0] er_cur;
      logic [EW-1:0]  es_cur;
      logic           ev_cur, eb_cur;
      logic [QWE+1:0] trial;
      if (k == 0) begin : g_first
         assign er_cur = QWE'(qn_ff[QW]);
         assign es_cur = '0;
         assign ev_cur = qv_ff[QW];
         assign eb_cur = qb_ff[QW];
      end else begin : g_next
         assign er_cur = er_ff[k];
         assign es_cur = es_ff[k];
         assign ev_cur = ev_ff[k];
         assign eb_cur = eb_ff[k];
      end
      assign trial = {2'b00, er_cur}
                   - (({2'b00, QWE'(es_cur)} << (B + 1)) | ((QWE+2)'(1) << (2 * B)));
      always_ff @(posedge clock) begin
         if (reset) ev_ff[k+1] <= 1'b0;
         else if (adv) ev_ff[k+1] <= ev_cur;
         if (adv) begin
            eb_ff[k+1] <= eb_cur;
            if (!trial[QWE+1]) begin
               er_ff[k+1] <= trial[QWE-1:0];
               es_ff[k+1] <= es_cur | (EW'(1) << B);
            end else begin
               er_ff[k+1] <= er_cur;
               es_ff[k+1] <= es_cur;
            end
         end
      end
   end

   // output register: clamp to one, then to the port width; a flagged result reads zero
   localparam logic [EW:0] ONE = (EW+1)'(1) << OUT_FRAC_BITS;
   logic [EW:0]      e_cl;
   logic [OUT_W-1:0] e_in;
   logic             ov_ff, onr_ff;
   logic [OUT_W-1:0] oe_ff;
   always_comb begin
      e_cl = ({1'b0, es_ff[EW]} > ONE) ? ONE : {1'b0, es_ff[EW]};
      if (EW + 1 > OUT_W && e_cl > (EW+1)'({OUT_W{1'b1}})) e_in = '1;
      else e_in = OUT_W'(e_cl);
   end
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= ev_ff[EW];
      if (adv) begin
         onr_ff <= eb_ff[EW];
         oe_ff  <= eb_ff[EW] ? '0 : e_in;
      end
   end
   assign rsp_valid        = ov_ff;
   assign rsp_not_round    = onr_ff;
   assign rsp_eccentricity = oe_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eccentricity))
      else $error("result lost under stall");
   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_round |-> rsp_eccentricity == '0)
      else $error("flagged result carries a value");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (EW+1)'(rsp_eccentricity) <= ONE)
      else $error("eccentricity above one");
endmodule
`default_nettype wire
